@@ hdl/osam_pkg.sv @@
package osam_pkg;

	// Field widths fixed by the word formats
	localparam int SPEED_W = 14;
	localparam int GAIN_W  = 11;
	localparam int TONE_W  = 12;
	localparam int LIMIT_W = 7;
	localparam int SHOWN_W = 15;
	localparam int BEEP_W  = 3;
	localparam int CFG_W   = 12;
	localparam int CFG_IDX_W = 3;

	// Datapath widths, sized for the largest history depth (16)
	localparam int SUM_W   = 18;          // 16 * 16383 < 2^18
	localparam int NUM_W   = 29;          // sum * gain
	localparam int PCT_W   = 20;          // overspeed percent
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 12;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int DVD_W   = 36;          // divider dividend, MSB aligned
	localparam int DVR_W   = 25;          // divider divisor
	localparam int STEP_W  = 5;           // two quotient bits per step

	// Step counts for the three divisions
	localparam logic [STEP_W-1:0] STEPS_SHOWN = 5'd10;
	localparam logic [STEP_W-1:0] STEPS_PCT   = 5'd18;
	localparam logic [STEP_W-1:0] STEPS_PITCH = 5'd16;

	localparam logic [SHOWN_W-1:0] SHOWN_MAX = 15'h7FFF;

	// Operation codes
	localparam logic OP_SPEED  = 1'b0;
	localparam logic OP_BUTTON = 1'b1;

	// Beep patterns
	localparam logic [BEEP_W-1:0] BEEP_NONE    = 3'd0;
	localparam logic [BEEP_W-1:0] BEEP_ACK     = 3'd1;
	localparam logic [BEEP_W-1:0] BEEP_REFUSED = 3'd2;
	localparam logic [BEEP_W-1:0] BEEP_RISING  = 3'd3;
	localparam logic [BEEP_W-1:0] BEEP_FALLING = 3'd4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_SPEED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAFETY_GAIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TONE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TONE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd4;

	// Register reset values
	localparam logic [9:0]         RST_FLOOR_SPEED = 10'd32;
	localparam logic [GAIN_W-1:0]  RST_SAFETY_GAIN = 11'd1075;
	localparam logic [TONE_W-1:0]  RST_MIN_TONE    = 12'd220;
	localparam logic [TONE_W-1:0]  RST_MAX_TONE    = 12'd800;
	localparam logic [7:0]         RST_FULL_SCALE  = 8'd50;

	typedef struct packed {
		logic               operation;
		logic [SPEED_W-1:0] speed_reading;
		logic               fix_ok;
		logic               green_pressed;
		logic               red_pressed;
	} osam_in_t;

	typedef struct packed {
		logic               tone_on;
		logic [TONE_W-1:0]  tone_hz;
		logic [BEEP_W-1:0]  beep_pattern;
		logic [LIMIT_W-1:0] limit_kmh;
		logic [SHOWN_W-1:0] shown_speed;
		logic               over_limit;
		logic               display_off;
	} osam_out_t;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
	} osam_div_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SUM,
		ST_MNUM,
		ST_GSHOW,
		ST_WSHOW,
		ST_CMP,
		ST_MPCT,
		ST_GPCT,
		ST_WPCT,
		ST_MSPAN,
		ST_GFS,
		ST_WFS,
		ST_DONE
	} osam_state_t;

	// Speed limit table in km/h, entries past the list repeat the top limit
	function automatic logic [LIMIT_W-1:0] limit_of(input logic [3:0] idx);
		logic [LIMIT_W-1:0] v;
		case (idx)
			4'd0:    v = 7'd5;
			4'd1:    v = 7'd10;
			4'd2:    v = 7'd15;
			4'd3:    v = 7'd20;
			4'd4:    v = 7'd25;
			4'd5:    v = 7'd30;
			4'd6:    v = 7'd50;
			4'd7:    v = 7'd60;
			4'd8:    v = 7'd80;
			4'd9:    v = 7'd100;
			default: v = 7'd120;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/overspeed_alarm_monitor.sv @@
// Channel  Direction  Word                       Handshake
// in       input      osam_pkg::osam_in_t        in_valid / in_stall
// out      output     osam_pkg::osam_out_t       out_valid / out_stall
// cfg      input      cfg_index, cfg_data        cfg_write
//
// From one accept to the next: button words and speed words with a bad fix
// run the history sum and the shown-speed division; a good fix adds the
// limit compare, and one above the limit adds the percent and pitch
// divisions as well. The result register loads as the block returns to
// idle. All divisions share the two-bit-per-cycle divider.
// Reset restores the register defaults and clears history, flags and tone.
// A new word is taken while the last result waits in the output register;
// a held out_stall pauses the block only at the end of the next word.
module overspeed_alarm_monitor #(
	parameter int HISTORY_DEPTH = 3,
	parameter int LIMIT_COUNT   = 11
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  osam_pkg::osam_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output osam_pkg::osam_out_t             out_data,
	input  logic                            cfg_write,
	input  logic [osam_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [osam_pkg::CFG_W-1:0]      cfg_data
);

	localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int LIM_SCALE = HISTORY_DEPTH * 16384;
	localparam logic [3:0] RST_INDEX = (LIMIT_COUNT > 6) ? 4'd6 : 4'(LIMIT_COUNT - 1);

	osam_pkg::osam_state_t state_q, state_nx;

	// Configuration
	logic [9:0]                       floor_q;
	logic [osam_pkg::GAIN_W-1:0]      gain_q;
	logic [osam_pkg::TONE_W-1:0]      min_tone_q;
	logic [osam_pkg::TONE_W-1:0]      max_tone_q;
	logic [7:0]                       full_scale_q;

	// Block state
	logic [osam_pkg::SPEED_W-1:0]     hist_q [HISTORY_DEPTH];
	logic [3:0]                       index_q;
	logic                             speeding_q;
	logic                             disabled_q;
	logic                             tone_active_q;
	logic [osam_pkg::TONE_W-1:0]      pitch_q;

	// Work registers
	osam_pkg::osam_in_t               in_q;
	logic [osam_pkg::BEEP_W-1:0]      beep_q;
	logic [IDX_W-1:0]                 cnt_q;
	logic [osam_pkg::SUM_W-1:0]       acc_q;
	logic [osam_pkg::MUL_P_W-1:0]     prod_q;
	logic [osam_pkg::NUM_W-1:0]       num_q;
	logic [osam_pkg::DVR_W-1:0]       lim_q;
	logic [osam_pkg::PCT_W-1:0]       pct_q;
	logic [osam_pkg::SHOWN_W-1:0]     shown_q;
	logic                             out_valid_q;
	osam_pkg::osam_out_t              out_q;

	logic                             accept;
	logic                             out_free;
	logic                             sum_last;
	logic                             over;
	logic                             span_neg;
	logic [osam_pkg::MUL_B_W-1:0]     span_mag;
	logic [7:0]                       fs_eff;
	logic [osam_pkg::SPEED_W-1:0]     reading;
	logic                             up_ok;
	logic                             mul_en;
	logic [osam_pkg::MUL_A_W-1:0]     mul_a;
	logic [osam_pkg::MUL_B_W-1:0]     mul_b;
	osam_pkg::osam_div_ctl_t          div_ctl;
	logic [osam_pkg::DVD_W-1:0]       div_dvd;
	logic [osam_pkg::DVR_W-1:0]       div_dvr;
	logic                             div_done;
	logic [osam_pkg::DVD_W-1:0]       div_quo;
	logic signed [33:0]               pitch_raw;
	logic [osam_pkg::TONE_W-1:0]      pitch_clamped;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != osam_pkg::ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign sum_last = (cnt_q == IDX_W'(HISTORY_DEPTH - 1));
	assign over     = (num_q > {4'b0, lim_q});
	assign span_neg = (max_tone_q < min_tone_q);
	assign span_mag = span_neg ? (min_tone_q - max_tone_q) : (max_tone_q - min_tone_q);
	assign fs_eff   = (full_scale_q == 8'd0) ? 8'd1 : full_scale_q;
	assign reading  = ({4'b0, floor_q} > in_data.speed_reading) ? '0 : in_data.speed_reading;
	assign up_ok    = ({1'b0, index_q} + 5'd1) < 5'(LIMIT_COUNT);

	// Pitch: min tone plus or minus scaled percent, clamped to [0, max tone]
	always_comb begin
		logic signed [33:0] pmin;
		logic signed [33:0] pq;
		pmin = $signed({22'b0, min_tone_q});
		pq   = $signed({2'b0, div_quo[31:0]});
		pitch_raw = span_neg ? (pmin - pq) : (pmin + pq);
		if (pitch_raw < 0) begin
			pitch_clamped = '0;
		end else if (pitch_raw > $signed({22'b0, max_tone_q})) begin
			pitch_clamped = max_tone_q;
		end else begin
			pitch_clamped = pitch_raw[osam_pkg::TONE_W-1:0];
		end
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			osam_pkg::ST_IDLE:  if (accept) state_nx = osam_pkg::ST_SUM;
			osam_pkg::ST_SUM:   if (sum_last) state_nx = osam_pkg::ST_MNUM;
			osam_pkg::ST_MNUM:  state_nx = osam_pkg::ST_GSHOW;
			osam_pkg::ST_GSHOW: state_nx = osam_pkg::ST_WSHOW;
			osam_pkg::ST_WSHOW: begin
				if (div_done) begin
					if (in_q.operation == osam_pkg::OP_SPEED && in_q.fix_ok)
						state_nx = osam_pkg::ST_CMP;
					else
						state_nx = osam_pkg::ST_DONE;
				end
			end
			osam_pkg::ST_CMP:   state_nx = over ? osam_pkg::ST_MPCT : osam_pkg::ST_DONE;
			osam_pkg::ST_MPCT:  state_nx = osam_pkg::ST_GPCT;
			osam_pkg::ST_GPCT:  state_nx = osam_pkg::ST_WPCT;
			osam_pkg::ST_WPCT:  if (div_done) state_nx = osam_pkg::ST_MSPAN;
			osam_pkg::ST_MSPAN: state_nx = osam_pkg::ST_GFS;
			osam_pkg::ST_GFS:   state_nx = osam_pkg::ST_WFS;
			osam_pkg::ST_WFS:   if (div_done) state_nx = osam_pkg::ST_DONE;
			osam_pkg::ST_DONE:  if (out_free) state_nx = osam_pkg::ST_IDLE;
			default:            state_nx = osam_pkg::ST_IDLE;
		endcase
	end

	// Shared multiplier and divider operand selection
	always_comb begin
		mul_en        = 1'b0;
		mul_a         = '0;
		mul_b         = '0;
		div_ctl.start = 1'b0;
		div_ctl.steps = osam_pkg::STEPS_SHOWN;
		div_dvd       = '0;
		div_dvr       = lim_q;
		case (state_q)
			osam_pkg::ST_MNUM: begin
				mul_en = 1'b1;
				mul_a  = osam_pkg::MUL_A_W'(acc_q);
				mul_b  = {1'b0, gain_q};
			end
			osam_pkg::ST_GSHOW: begin
				// average: (num >> 10) / depth
				div_ctl.start = 1'b1;
				div_ctl.steps = osam_pkg::STEPS_SHOWN;
				div_dvd = {1'b0, prod_q[osam_pkg::NUM_W-1:10], 16'b0};
				div_dvr = osam_pkg::DVR_W'(HISTORY_DEPTH);
			end
			osam_pkg::ST_MPCT: begin
				mul_en = 1'b1;
				mul_a  = osam_pkg::MUL_A_W'(num_q - {4'b0, lim_q});
				mul_b  = 12'd100;
			end
			osam_pkg::ST_GPCT: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = osam_pkg::STEPS_PCT;
				div_dvd = prod_q[osam_pkg::DVD_W-1:0];
				div_dvr = lim_q;
			end
			osam_pkg::ST_MSPAN: begin
				mul_en = 1'b1;
				mul_a  = osam_pkg::MUL_A_W'(pct_q);
				mul_b  = span_mag;
			end
			osam_pkg::ST_GFS: begin
				div_ctl.start = 1'b1;
				div_ctl.steps = osam_pkg::STEPS_PITCH;
				div_dvd = {prod_q[31:0], 4'b0};
				div_dvr = {17'b0, fs_eff};
			end
			default: begin
			end
		endcase
	end

	osam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (div_dvd),
		.divisor  (div_dvr),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Control state, configuration and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= osam_pkg::ST_IDLE;
			floor_q       <= osam_pkg::RST_FLOOR_SPEED;
			gain_q        <= osam_pkg::RST_SAFETY_GAIN;
			min_tone_q    <= osam_pkg::RST_MIN_TONE;
			max_tone_q    <= osam_pkg::RST_MAX_TONE;
			full_scale_q  <= osam_pkg::RST_FULL_SCALE;
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
			index_q       <= RST_INDEX;
			speeding_q    <= 1'b0;
			disabled_q    <= 1'b0;
			tone_active_q <= 1'b0;
			pitch_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nx;

			// register writes
			if (cfg_write) begin
				case (cfg_index)
					osam_pkg::CFG_FLOOR_SPEED: floor_q      <= cfg_data[9:0];
					osam_pkg::CFG_SAFETY_GAIN: gain_q       <= cfg_data[osam_pkg::GAIN_W-1:0];
					osam_pkg::CFG_MIN_TONE:    min_tone_q   <= cfg_data;
					osam_pkg::CFG_MAX_TONE:    max_tone_q   <= cfg_data;
					osam_pkg::CFG_FULL_SCALE:  full_scale_q <= cfg_data[7:0];
					default: begin
					end
				endcase
			end

			// word arrival: history shift or button handling
			if (accept) begin
				if (in_data.operation == osam_pkg::OP_SPEED) begin
					for (int i = HISTORY_DEPTH - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
					hist_q[0] <= reading;
					if (!in_data.fix_ok) tone_active_q <= 1'b0;
				end else if (in_data.green_pressed && in_data.red_pressed) begin
					disabled_q    <= !disabled_q;
					tone_active_q <= 1'b0;
				end else if (in_data.green_pressed || in_data.red_pressed) begin
					tone_active_q <= 1'b0;
					if (in_data.green_pressed && up_ok)
						index_q <= index_q + 4'd1;
					else if (in_data.red_pressed && index_q != 4'd0)
						index_q <= index_q - 4'd1;
				end
			end

			// back at or below the limit
			if (state_q == osam_pkg::ST_CMP && !over && speeding_q) begin
				speeding_q    <= 1'b0;
				tone_active_q <= 1'b0;
			end

			// new warning pitch
			if (state_q == osam_pkg::ST_WFS && div_done) begin
				pitch_q       <= pitch_clamped;
				tone_active_q <= 1'b1;
				speeding_q    <= 1'b1;
			end

			// output register
			if (state_q == osam_pkg::ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q  <= in_data;
			acc_q <= '0;
			cnt_q <= '0;
			if (in_data.operation == osam_pkg::OP_SPEED)
				beep_q <= osam_pkg::BEEP_NONE;
			else if (in_data.green_pressed && in_data.red_pressed)
				beep_q <= disabled_q ? osam_pkg::BEEP_RISING : osam_pkg::BEEP_FALLING;
			else if (in_data.green_pressed && up_ok)
				beep_q <= osam_pkg::BEEP_ACK;
			else if (in_data.red_pressed && index_q != 4'd0)
				beep_q <= osam_pkg::BEEP_ACK;
			else if (in_data.green_pressed || in_data.red_pressed)
				beep_q <= osam_pkg::BEEP_REFUSED;
			else
				beep_q <= osam_pkg::BEEP_NONE;
		end

		// history sum, one entry per cycle
		if (state_q == osam_pkg::ST_SUM) begin
			acc_q <= acc_q + osam_pkg::SUM_W'(hist_q[cnt_q]);
			cnt_q <= cnt_q + 1'b1;
		end

		if (mul_en)
			prod_q <= osam_pkg::MUL_P_W'(mul_a) * osam_pkg::MUL_P_W'(mul_b);

		// limit in the same scale as sum * gain
		if (state_q == osam_pkg::ST_MNUM)
			lim_q <= osam_pkg::DVR_W'(32'(osam_pkg::limit_of(index_q)) * 32'(LIM_SCALE));

		if (state_q == osam_pkg::ST_GSHOW)
			num_q <= prod_q[osam_pkg::NUM_W-1:0];

		if (state_q == osam_pkg::ST_WSHOW && div_done)
			shown_q <= (div_quo > osam_pkg::DVD_W'(osam_pkg::SHOWN_MAX)) ?
				osam_pkg::SHOWN_MAX : div_quo[osam_pkg::SHOWN_W-1:0];

		if (state_q == osam_pkg::ST_WPCT && div_done)
			pct_q <= div_quo[osam_pkg::PCT_W-1:0];

		if (state_q == osam_pkg::ST_DONE && out_free) begin
			out_q.tone_on      <= tone_active_q;
			out_q.tone_hz      <= tone_active_q ? pitch_q : '0;
			out_q.beep_pattern <= beep_q;
			out_q.limit_kmh    <= osam_pkg::limit_of(index_q);
			out_q.shown_speed  <= shown_q;
			out_q.over_limit   <= speeding_q;
			out_q.display_off  <= disabled_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

@@ hdl/osam_div.sv @@
// Restoring divider, two quotient bits per cycle.
// Dividend comes in MSB aligned; after the given number of steps the whole
// quotient register holds the quotient.
module osam_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  osam_pkg::osam_div_ctl_t       ctl,
	input  logic [osam_pkg::DVD_W-1:0]    dividend,
	input  logic [osam_pkg::DVR_W-1:0]    divisor,
	output logic                          done,
	output logic [osam_pkg::DVD_W-1:0]    quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [osam_pkg::STEP_W-1:0]   cnt_q;
	logic [osam_pkg::DVR_W-1:0]    rem_q;
	logic [osam_pkg::DVD_W-1:0]    quo_q;
	logic [osam_pkg::DVR_W-1:0]    dvr_q;
	logic [osam_pkg::DVR_W-1:0]    rem_nx;
	logic [osam_pkg::DVD_W-1:0]    quo_nx;

	// Two shift-subtract steps
	always_comb begin
		logic [osam_pkg::DVR_W:0] t;
		rem_nx = rem_q;
		quo_nx = quo_q;
		for (int k = 0; k < 2; k++) begin
			t = {rem_nx, quo_nx[osam_pkg::DVD_W-1]};
			quo_nx = {quo_nx[osam_pkg::DVD_W-2:0], 1'b0};
			if (t >= {1'b0, dvr_q}) begin
				rem_nx = osam_pkg::DVR_W'(t - {1'b0, dvr_q});
				quo_nx[0] = 1'b1;
			end else begin
				rem_nx = t[osam_pkg::DVR_W-1:0];
			end
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= ctl.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == osam_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= quo_nx;
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ dv/testbench.sv @@
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 80;
	localparam int DEPTH       = 3;

	logic                osam_clk_unused;
	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	osam_pkg::osam_in_t  in_data = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	osam_pkg::osam_out_t out_data;
	logic                           cfg_write = 1'b0;
	logic [osam_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [osam_pkg::CFG_W-1:0]     cfg_data = '0;

	overspeed_alarm_monitor uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Words waiting to be offered and results waiting to be seen
	osam_pkg::osam_in_t  alarm_pending[$];
	osam_pkg::osam_out_t alarm_expected[$];

	int items_queued = 0;
	int results_seen = 0;
	int speeding_results = 0;
	int reg_writes = 0;
	int fail_count = 0;
	int cycle_count = 0;
	int hold_requests = 0;
	bit in_gappy = 1'b1;
	bit out_gappy = 1'b1;

	// Shadow of the alarm state
	logic [osam_pkg::SPEED_W-1:0] hist [0:DEPTH-1] = '{default: '0};
	logic [3:0]                   pred_idx = 4'd6;
	logic                         speeding = 1'b0;
	logic                         disabled = 1'b0;
	logic                         tone_act = 1'b0;
	logic [osam_pkg::TONE_W-1:0]  pitch = '0;
	logic [6:0]         limit_tab [0:10] = '{7'd5, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30,
		7'd50, 7'd60, 7'd80, 7'd100, 7'd120};

	// Shadow of the registers
	logic [9:0]                  cfg_floor = 10'd32;
	logic [osam_pkg::GAIN_W-1:0] cfg_gain = 11'd1075;
	logic [osam_pkg::TONE_W-1:0] cfg_min_hz = 12'd220;
	logic [osam_pkg::TONE_W-1:0] cfg_max_hz = 12'd800;
	logic [7:0]                  cfg_full_pct = 8'd50;

	osam_pkg::osam_out_t want_word;
	int stall_left = 0;
	int hold_left = 0;
	int hold_served = 0;
	int gap_left = 0;

	initial begin
		forever #4 clk = ~clk;
	end

	// Sum of history times gain, scaled by DEPTH * 1024
	function automatic longint unsigned history_gain_product();
		longint unsigned sum;
		sum = 0;
		for (int i = 0; i < DEPTH; i++)
			sum += hist[i];
		return sum * cfg_gain;
	endfunction

	// Advance the shadow state by one accepted word and queue its result
	task automatic predict_alarm_word(input osam_pkg::osam_in_t w);
		longint unsigned num, lim, shown;
		longint pct, span, fs, p;
		logic [osam_pkg::SPEED_W-1:0] rd;
		logic [osam_pkg::BEEP_W-1:0] beep;
		osam_pkg::osam_out_t r;
		beep = osam_pkg::BEEP_NONE;
		if (w.operation == osam_pkg::OP_SPEED) begin
			rd = (w.speed_reading < cfg_floor) ? '0 : w.speed_reading;
			for (int i = DEPTH - 1; i > 0; i--)
				hist[i] = hist[i-1];
			hist[0] = rd;
			if (w.fix_ok) begin
				num = history_gain_product();
				lim = longint'(limit_tab[pred_idx]) * 16 * DEPTH * 1024;
				if (num <= lim) begin
					if (speeding) begin
						speeding = 1'b0;
						tone_act = 1'b0;
					end
				end else begin
					pct = longint'(((num - lim) * 100) / lim);
					span = longint'(cfg_max_hz) - longint'(cfg_min_hz);
					fs = (cfg_full_pct == 0) ? 1 : longint'(cfg_full_pct);
					p = pct * span / fs + longint'(cfg_min_hz);
					if (p > longint'(cfg_max_hz))
						p = longint'(cfg_max_hz);
					if (p < 0)
						p = 0;
					pitch = p[osam_pkg::TONE_W-1:0];
					tone_act = 1'b1;
					speeding = 1'b1;
				end
			end else begin
				tone_act = 1'b0;
			end
		end else if (w.green_pressed && w.red_pressed) begin
			disabled = !disabled;
			beep = disabled ? osam_pkg::BEEP_FALLING : osam_pkg::BEEP_RISING;
			tone_act = 1'b0;
		end else if (w.green_pressed || w.red_pressed) begin
			tone_act = 1'b0;
			if (w.green_pressed && pred_idx < 4'd10) begin
				pred_idx++;
				beep = osam_pkg::BEEP_ACK;
			end else if (w.red_pressed && pred_idx > 4'd0) begin
				pred_idx--;
				beep = osam_pkg::BEEP_ACK;
			end else begin
				beep = osam_pkg::BEEP_REFUSED;
			end
		end

		shown = history_gain_product() / (DEPTH * 1024);
		if (shown > 32767)
			shown = 32767;
		r.tone_on = tone_act;
		r.tone_hz = tone_act ? pitch : '0;
		r.beep_pattern = beep;
		r.limit_kmh = limit_tab[pred_idx];
		r.shown_speed = shown[osam_pkg::SHOWN_W-1:0];
		r.over_limit = speeding;
		r.display_off = disabled;
		alarm_expected.push_back(r);
	endtask

	task automatic compare_field(input string name, input longint unsigned want,
		input longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Driver: offers pending words, predicts each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall)
				predict_alarm_word(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (alarm_pending.size() > 0) begin
					in_data <= alarm_pending.pop_front();
					in_valid <= 1'b1;
					gap_left = in_gappy ? $urandom_range(0, 16) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word, draws output stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (alarm_expected.size() == 0) begin
					$error("result word with no pending prediction");
					fail_count++;
				end else begin
					want_word = alarm_expected.pop_front();
					if (want_word.over_limit)
						speeding_results++;
					compare_field("tone_on", want_word.tone_on, out_data.tone_on);
					compare_field("tone_hz", want_word.tone_hz, out_data.tone_hz);
					compare_field("beep_pattern", want_word.beep_pattern, out_data.beep_pattern);
					compare_field("limit_kmh", want_word.limit_kmh, out_data.limit_kmh);
					compare_field("shown_speed", want_word.shown_speed, out_data.shown_speed);
					compare_field("over_limit", want_word.over_limit, out_data.over_limit);
					compare_field("display_off", want_word.display_off, out_data.display_off);
				end
				stall_left = out_gappy ? $urandom_range(0, 16) : 0;
			end
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("overspeed_alarm_monitor verification failed");
		$finish;
	end

	function automatic osam_pkg::osam_in_t speed_word(input int reading, input bit fix);
		osam_pkg::osam_in_t w;
		w.operation = osam_pkg::OP_SPEED;
		w.speed_reading = reading[osam_pkg::SPEED_W-1:0];
		w.fix_ok = fix;
		w.green_pressed = $urandom_range(0, 1);
		w.red_pressed = $urandom_range(0, 1);
		return w;
	endfunction

	function automatic osam_pkg::osam_in_t button_word(input bit green, input bit red);
		osam_pkg::osam_in_t w;
		w.operation = osam_pkg::OP_BUTTON;
		w.speed_reading = $urandom_range(0, 16383);
		w.fix_ok = $urandom_range(0, 1);
		w.green_pressed = green;
		w.red_pressed = red;
		return w;
	endfunction

	// Keep the pending queue short so the shadow limit stays current
	task automatic queue_word(input osam_pkg::osam_in_t w);
		while (alarm_pending.size() >= 2)
			@(posedge clk);
		alarm_pending.push_back(w);
		items_queued++;
	endtask

	task automatic wait_results();
		while (results_seen != items_queued)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_register(input logic [osam_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[osam_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			osam_pkg::CFG_FLOOR_SPEED: cfg_floor = val[9:0];
			osam_pkg::CFG_SAFETY_GAIN: cfg_gain = val[osam_pkg::GAIN_W-1:0];
			osam_pkg::CFG_MIN_TONE:    cfg_min_hz = val[osam_pkg::TONE_W-1:0];
			osam_pkg::CFG_MAX_TONE:    cfg_max_hz = val[osam_pkg::TONE_W-1:0];
			osam_pkg::CFG_FULL_SCALE:  cfg_full_pct = val[7:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic set_all(input int unsigned floor_v, input int unsigned gain_v,
		input int unsigned min_v, input int unsigned max_v, input int unsigned fs_v);
		set_register(osam_pkg::CFG_FLOOR_SPEED, floor_v);
		set_register(osam_pkg::CFG_SAFETY_GAIN, gain_v);
		set_register(osam_pkg::CFG_MIN_TONE, min_v);
		set_register(osam_pkg::CFG_MAX_TONE, max_v);
		set_register(osam_pkg::CFG_FULL_SCALE, fs_v);
	endtask

	// Mostly good fixes around the current limit, plus muted fixes,
	// odd readings and button presses
	task automatic run_random(input int count);
		int kind, pick, reading, target;
		bit green, red;
		for (int i = 0; i < count; i++) begin
			if (i % 32 == 0) begin
				in_gappy = ($urandom_range(0, 2) != 0);
				out_gappy = ($urandom_range(0, 2) != 0);
			end
			kind = $urandom_range(0, 99);
			if (kind < 58) begin
				target = int'(limit_tab[pred_idx]) * 16 * 1024 / int'(cfg_gain);
				reading = target * $urandom_range(60, 150) / 100;
				if (reading > 16383)
					reading = 16383;
				queue_word(speed_word(reading, 1'b1));
			end else if (kind < 66) begin
				queue_word(speed_word($urandom_range(0, 16383), 1'b0));
			end else if (kind < 74) begin
				pick = $urandom_range(0, 4);
				case (pick)
					0: reading = 0;
					1: reading = 16383;
					2: reading = cfg_floor;
					3: reading = (cfg_floor > 0) ? cfg_floor - 1 : 0;
					default: reading = $urandom_range(0, 16383);
				endcase
				queue_word(speed_word(reading, $urandom_range(0, 1)));
			end else begin
				pick = $urandom_range(0, 9);
				green = (pick < 4) || (pick == 8);
				red = (pick >= 4 && pick < 8) || (pick == 8);
				if ($urandom_range(0, 15) == 0) begin
					// a run long enough to reach a bound from anywhere
					for (int k = 0; k < 11; k++)
						queue_word(button_word(green, red));
				end else begin
					queue_word(button_word(green, red));
				end
			end
		end
	endtask

	// Exact limit boundary with unity gain and no floor
	task automatic run_boundary();
		int edge_rd;
		edge_rd = int'(limit_tab[pred_idx]) * 16;
		repeat (3) queue_word(speed_word(edge_rd, 1'b1));
		queue_word(speed_word(edge_rd + 1, 1'b1));
		repeat (3) queue_word(speed_word(edge_rd, 1'b1));
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset registers, zero and full-scale speed, floor edge,
		// bad fix, drop back, each button case but a refused red, and the top bound
		in_gappy = 1'b1;
		out_gappy = 1'b1;
		queue_word(speed_word(0, 1'b1));
		queue_word(speed_word(31, 1'b1));
		queue_word(speed_word(32, 1'b1));
		queue_word(speed_word(16383, 1'b1));
		queue_word(speed_word(16383, 1'b1));
		queue_word(speed_word(16383, 1'b0));
		queue_word(speed_word(16383, 1'b1));
		repeat (3) queue_word(speed_word(0, 1'b1));
		queue_word(button_word(1'b0, 1'b0));
		queue_word(speed_word(16383, 1'b1));
		repeat (5) queue_word(button_word(1'b1, 1'b0));
		queue_word(button_word(1'b1, 1'b1));
		queue_word(button_word(1'b1, 1'b1));
		queue_word(button_word(1'b0, 1'b1));
		wait_results();

		set_all(0, 1024, 220, 800, 50);
		run_boundary();
		wait_results();
		run_random(100);
		wait_results();

		// Extreme registers: top floor and gain, falling pitch span
		set_all(1023, 2047, 4095, 0, 255);
		run_random(80);
		wait_results();

		// Zero full scale, widest pitch span
		set_all(0, 1024, 0, 4095, 0);
		run_random(80);
		wait_results();

		// Long output hold while the sender keeps offering words
		set_all(500, 1536, 1000, 1000, 1);
		hold_requests++;
		in_gappy = 1'b0;
		for (int i = 0; i < 40; i++)
			queue_word(speed_word($urandom_range(0, 16383), $urandom_range(0, 1)));
		run_random(50);
		wait_results();

		// Back to power-on values, with a full pause partway through
		set_all(32, 1075, 220, 800, 50);
		run_random(60);
		wait_results();
		run_random(60);
		wait_results();

		set_all(100, 1800, 3000, 200, 128);
		run_random(80);

		wait_results();
		if (alarm_expected.size() != 0) begin
			$error("%0d predicted results never arrived", alarm_expected.size());
			fail_count++;
		end
		$display("Sent %0d words over %0d register writes; %0d results checked, %0d speeding.",
			items_queued, reg_writes, results_seen, speeding_results);
		$display("Gaps and stalls varied by phase, one long output hold backed up the input.");
		if (fail_count == 0) begin
			$display("overspeed_alarm_monitor verification clean");
		end else begin
			$display("overspeed_alarm_monitor verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/osam_pkg.sv
hdl/osam_div.sv
hdl/overspeed_alarm_monitor.sv
dv/testbench.sv
